// ===== sv/npc_pkg.sv =====
package npc_pkg;

    localparam int COLOR_W = 8;
    localparam int DIST_W  = 18;
    localparam int LEN_W   = 9;
    localparam int IN_USES_W  = 24;
    localparam int OUT_USES_W = 24;
    localparam int OUT_IDX_W  = 8;

    localparam logic [DIST_W-1:0] NO_MATCH_DIST = 18'd196608;
    localparam logic [LEN_W-1:0]  LEN_RESET     = 9'd254;

    // default palette layout
    localparam int IDX_WHITE      = 0;
    localparam int IDX_BLACK      = 1;
    localparam int IDX_CUBE_FIRST = 2;
    localparam int IDX_CUBE_LAST  = 217;
    localparam int IDX_GRAY_FIRST = 218;
    localparam int IDX_GRAY_LAST  = 222;
    localparam int IDX_BLACK_END  = 253;
    localparam int CUBE_STEP      = 51;
    localparam int CUBE_DIGIT_MAX = 5;
    localparam int GRAY_STEP      = 25;
    localparam int FULL_LEVEL     = 255;
    localparam int USES_BASE      = 2000000;
    localparam int USES_CUBE      = 1000000;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_MAP   = 1'b1
    } t_action;

    typedef struct packed {
        logic init_en;   // write one default entry, advance sweep
        logic wr_entry;  // store a write item
        logic load;      // latch map color, clear search state
        logic scan_en;   // issue reads and run compare pipeline
        logic uses_rd;   // read use count of chosen entry
        logic uses_wr;   // write back count, present result
    } t_cmd;

    typedef struct packed {
        logic init_last;
        logic scan_done;
    } t_stat;

endpackage

// ===== sv/npc_ctrl.sv =====
module npc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_action,
    input  npc_pkg::t_stat i_stat,
    output npc_pkg::t_cmd  o_cmd,
    output logic          o_busy
);
    import npc_pkg::*;

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_UPD_RD = 5'b01000,
        S_UPD_WR = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_en = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (t_action'(i_action) == ACT_MAP) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_SCAN;
                    end else begin
                        o_cmd.wr_entry = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_UPD_RD;
                end
            end
            S_UPD_RD: begin
                o_cmd.uses_rd = 1'b1;
                n_state       = S_UPD_WR;
            end
            S_UPD_WR: begin
                o_cmd.uses_wr = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/npc_dpath.sv =====
module npc_dpath #(
    parameter int PALETTE_DEPTH  = 256,
    parameter int USE_COUNT_BITS = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  npc_pkg::t_cmd                      i_cmd,
    output npc_pkg::t_stat                     o_stat,
    input  logic                               i_cfg_wr_en,
    input  logic [npc_pkg::LEN_W-1:0]          i_cfg_wr_data,
    input  logic [7:0]                         i_entry_index,
    input  logic [npc_pkg::COLOR_W-1:0]        i_red_value,
    input  logic [npc_pkg::COLOR_W-1:0]        i_green_value,
    input  logic [npc_pkg::COLOR_W-1:0]        i_blue_value,
    input  logic                               i_reserved_mark,
    input  logic [npc_pkg::IN_USES_W-1:0]      i_initial_uses,
    output logic                               o_done,
    output logic [npc_pkg::OUT_IDX_W-1:0]      o_color_index,
    output logic [npc_pkg::DIST_W-1:0]         o_least_distance,
    output logic [npc_pkg::OUT_USES_W-1:0]     o_uses_after
);
    import npc_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int WW = 1 + 3 * COLOR_W;
    localparam int SQ_W = 2 * COLOR_W;
    localparam logic [USE_COUNT_BITS-1:0] USE_MAX = '1;

    // palette word: {reserved, red, green, blue}
    logic [WW-1:0]             r_color_mem [PALETTE_DEPTH];
    logic [USE_COUNT_BITS-1:0] r_uses_mem  [PALETTE_DEPTH];

    logic [LEN_W-1:0]   r_len;
    logic [CW-1:0]      r_limit;
    logic [CW-1:0]      r_idx;
    logic [AW-1:0]      r_sweep;
    logic [2:0]         r_cube_r, r_cube_g, r_cube_b;
    logic [COLOR_W-1:0] r_key_r, r_key_g, r_key_b;

    logic               r_v1, r_v2;
    logic [AW-1:0]      r_i1, r_i2;
    logic [WW-1:0]      r_rd_word;
    logic               r_res2;
    logic [SQ_W-1:0]    r_sq_r, r_sq_g, r_sq_b;

    logic [DIST_W-1:0]  r_best_dist;
    logic [AW-1:0]      r_best_idx;
    logic [USE_COUNT_BITS-1:0] r_uses_rd;

    logic               r_done;
    logic [OUT_IDX_W-1:0]  r_out_idx;
    logic [DIST_W-1:0]     r_out_dist;
    logic [OUT_USES_W-1:0] r_out_uses;

    // default entry at sweep address
    logic [31:0]               sweep_ext;
    logic [COLOR_W-1:0]        def_r, def_g, def_b;
    logic [31:0]               def_uses_raw;
    logic [USE_COUNT_BITS-1:0] def_uses;
    logic                      in_cube;
    logic [31:0]               gray_lvl;

    // write port
    logic                      col_we, uses_we;
    logic [AW-1:0]             wr_addr;
    logic [WW-1:0]             col_wdata;
    logic [USE_COUNT_BITS-1:0] uses_wdata;
    logic [USE_COUNT_BITS-1:0] in_uses_sat;
    logic [USE_COUNT_BITS-1:0] uses_inc;
    logic                      entry_ok;

    // scan
    logic                      issue;
    logic [COLOR_W-1:0]        dr, dg, db;
    logic [COLOR_W-1:0]        pr, pg, pb;
    logic [DIST_W-1:0]         dist_sum;

    assign sweep_ext = 32'(r_sweep);
    assign in_cube   = (sweep_ext >= IDX_CUBE_FIRST) && (sweep_ext <= IDX_CUBE_LAST);
    assign gray_lvl  = ((sweep_ext - IDX_GRAY_FIRST) * 2 + 1) * GRAY_STEP;

    always_comb begin
        def_r        = '0;
        def_g        = '0;
        def_b        = '0;
        def_uses_raw = '0;
        if (sweep_ext == IDX_WHITE) begin
            def_r        = COLOR_W'(FULL_LEVEL);
            def_g        = COLOR_W'(FULL_LEVEL);
            def_b        = COLOR_W'(FULL_LEVEL);
            def_uses_raw = USES_BASE;
        end else if (sweep_ext == IDX_BLACK || sweep_ext == IDX_BLACK_END) begin
            def_uses_raw = USES_BASE;
        end else if (in_cube) begin
            def_r        = COLOR_W'(32'(r_cube_r) * CUBE_STEP);
            def_g        = COLOR_W'(32'(r_cube_g) * CUBE_STEP);
            def_b        = COLOR_W'(32'(r_cube_b) * CUBE_STEP);
            def_uses_raw = USES_CUBE;
        end else if (sweep_ext >= IDX_GRAY_FIRST && sweep_ext <= IDX_GRAY_LAST) begin
            def_r        = COLOR_W'(gray_lvl);
            def_g        = COLOR_W'(gray_lvl);
            def_b        = COLOR_W'(gray_lvl);
            def_uses_raw = USES_BASE;
        end
    end

    assign def_uses = (def_uses_raw > 32'(USE_MAX)) ? USE_MAX
                                                    : USE_COUNT_BITS'(def_uses_raw);
    assign in_uses_sat = (32'(i_initial_uses) > 32'(USE_MAX)) ? USE_MAX
                       : USE_COUNT_BITS'(32'(i_initial_uses));
    assign uses_inc = (r_uses_rd == USE_MAX) ? USE_MAX : r_uses_rd + 1'b1;
    assign entry_ok = (32'(i_entry_index) < PALETTE_DEPTH);

    always_comb begin
        col_we     = 1'b0;
        uses_we    = 1'b0;
        wr_addr    = r_best_idx;
        col_wdata  = {i_reserved_mark, i_red_value, i_green_value, i_blue_value};
        uses_wdata = uses_inc;
        if (i_cmd.init_en) begin
            col_we     = 1'b1;
            uses_we    = 1'b1;
            wr_addr    = r_sweep;
            col_wdata  = {1'b0, def_r, def_g, def_b};
            uses_wdata = def_uses;
        end else if (i_cmd.wr_entry) begin
            col_we     = entry_ok;
            uses_we    = entry_ok;
            wr_addr    = AW'(32'(i_entry_index));
            uses_wdata = in_uses_sat;
        end else if (i_cmd.uses_wr) begin
            uses_we = 1'b1;
        end
    end

    assign issue = i_cmd.scan_en && (r_idx < r_limit);

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_color_mem[wr_addr] <= col_wdata;
        end
        r_rd_word <= r_color_mem[r_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (uses_we) begin
            r_uses_mem[wr_addr] <= uses_wdata;
        end
        if (i_cmd.uses_rd) begin
            r_uses_rd <= r_uses_mem[r_best_idx];
        end
    end

    // sweep address and cube digits, blue fastest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep  <= '0;
            r_cube_r <= '0;
            r_cube_g <= '0;
            r_cube_b <= '0;
        end else if (i_cmd.init_en) begin
            r_sweep <= r_sweep + 1'b1;
            if (in_cube) begin
                if (r_cube_b == 3'(CUBE_DIGIT_MAX)) begin
                    r_cube_b <= '0;
                    if (r_cube_g == 3'(CUBE_DIGIT_MAX)) begin
                        r_cube_g <= '0;
                        r_cube_r <= r_cube_r + 1'b1;
                    end else begin
                        r_cube_g <= r_cube_g + 1'b1;
                    end
                end else begin
                    r_cube_b <= r_cube_b + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_len <= i_cfg_wr_data;
        end
    end

    // stage 1 -> 2: absolute differences and squares
    assign pr = r_rd_word[3*COLOR_W-1:2*COLOR_W];
    assign pg = r_rd_word[2*COLOR_W-1:COLOR_W];
    assign pb = r_rd_word[COLOR_W-1:0];
    assign dr = (pr > r_key_r) ? pr - r_key_r : r_key_r - pr;
    assign dg = (pg > r_key_g) ? pg - r_key_g : r_key_g - pg;
    assign db = (pb > r_key_b) ? pb - r_key_b : r_key_b - pb;
    assign dist_sum = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key_r     <= i_red_value;
            r_key_g     <= i_green_value;
            r_key_b     <= i_blue_value;
            r_idx       <= '0;
            r_limit     <= (32'(r_len) > PALETTE_DEPTH) ? CW'(PALETTE_DEPTH) : CW'(r_len);
            r_best_dist <= NO_MATCH_DIST;
            r_best_idx  <= '0;
        end else begin
            if (issue) begin
                r_idx <= r_idx + 1'b1;
            end
            // keep the first entry on ties
            if (r_v2 && !r_res2 && (dist_sum < r_best_dist)) begin
                r_best_dist <= dist_sum;
                r_best_idx  <= r_i2;
            end
        end
        r_i1   <= r_idx[AW-1:0];
        r_i2   <= r_i1;
        r_res2 <= r_rd_word[WW-1];
        r_sq_r <= dr * dr;
        r_sq_g <= dg * dg;
        r_sq_b <= db * db;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.uses_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uses_wr) begin
            r_out_idx  <= OUT_IDX_W'(32'(r_best_idx));
            r_out_dist <= r_best_dist;
            r_out_uses <= OUT_USES_W'(32'(uses_inc));
        end
    end

    assign o_stat.init_last = (32'(r_sweep) == PALETTE_DEPTH - 1);
    assign o_stat.scan_done = (r_idx >= r_limit) && !r_v1 && !r_v2;

    assign o_done           = r_done;
    assign o_color_index    = r_out_idx;
    assign o_least_distance = r_out_dist;
    assign o_uses_after     = r_out_uses;

endmodule

// ===== sv/nearest_palette_color_unit.sv =====
// Nearest palette color unit. After reset the block loads its default palette, one
// entry per cycle, holding o_busy high until the last entry is written. An item is taken
// when i_start is high and o_busy is low. A write item (i_action 0) is stored while the
// block stays idle and gives no result. A map item scans entries 0 .. min(palette_length,
// PALETTE_DEPTH)-1 one per cycle through a single color memory read port and a
// three-stage compare pipeline, then reads and writes back the chosen entry's use count
// with o_busy high throughout; o_done then pulses for one cycle with the result in the
// first cycle that o_busy is low again. The result outputs then hold until the next map
// item ends; the receiver cannot stall them. The user writes the palette length register
// through i_cfg_wr_en / i_cfg_wr_data only while idle; the block does not enforce it.
module nearest_palette_color_unit #(
    parameter int PALETTE_DEPTH  = 256,
    parameter int USE_COUNT_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic                           i_cfg_wr_en,
    input  logic [npc_pkg::LEN_W-1:0]      i_cfg_wr_data,
    input  logic                           i_action,
    input  logic [7:0]                     i_entry_index,
    input  logic [npc_pkg::COLOR_W-1:0]    i_red_value,
    input  logic [npc_pkg::COLOR_W-1:0]    i_green_value,
    input  logic [npc_pkg::COLOR_W-1:0]    i_blue_value,
    input  logic                           i_reserved_mark,
    input  logic [npc_pkg::IN_USES_W-1:0]  i_initial_uses,
    output logic                           o_done,
    output logic [npc_pkg::OUT_IDX_W-1:0]  o_color_index,
    output logic [npc_pkg::DIST_W-1:0]     o_least_distance,
    output logic [npc_pkg::OUT_USES_W-1:0] o_uses_after
);
    import npc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    npc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    npc_dpath #(
        .PALETTE_DEPTH  (PALETTE_DEPTH),
        .USE_COUNT_BITS (USE_COUNT_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_entry_index    (i_entry_index),
        .i_red_value      (i_red_value),
        .i_green_value    (i_green_value),
        .i_blue_value     (i_blue_value),
        .i_reserved_mark  (i_reserved_mark),
        .i_initial_uses   (i_initial_uses),
        .o_done           (o_done),
        .o_color_index    (o_color_index),
        .o_least_distance (o_least_distance),
        .o_uses_after     (o_uses_after)
    );

endmodule

// ===== test/palette_match_checker.sv =====
`timescale 1ns / 100ps

module palette_match_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_busy,
    input  logic                           i_cfg_wr_en,
    input  logic [npc_pkg::LEN_W-1:0]      i_cfg_wr_data,
    input  logic                           i_action,
    input  logic [7:0]                     i_entry_index,
    input  logic [npc_pkg::COLOR_W-1:0]    i_red_value,
    input  logic [npc_pkg::COLOR_W-1:0]    i_green_value,
    input  logic [npc_pkg::COLOR_W-1:0]    i_blue_value,
    input  logic                           i_reserved_mark,
    input  logic [npc_pkg::IN_USES_W-1:0]  i_initial_uses,
    input  logic                           i_done,
    input  logic [npc_pkg::OUT_IDX_W-1:0]  i_color_index,
    input  logic [npc_pkg::DIST_W-1:0]     i_least_distance,
    input  logic [npc_pkg::OUT_USES_W-1:0] i_uses_after,
    output int                             o_fail_count,
    output int                             o_pending
);
    import npc_pkg::*;

    localparam int DEPTH = 256;
    localparam logic [OUT_USES_W-1:0] USES_MAX = '1;

    typedef struct packed {
        logic [OUT_IDX_W-1:0]  index;
        logic [DIST_W-1:0]     distance;
        logic [OUT_USES_W-1:0] uses;
    } t_match;

    logic [COLOR_W-1:0]    pal_red     [DEPTH];
    logic [COLOR_W-1:0]    pal_green   [DEPTH];
    logic [COLOR_W-1:0]    pal_blue    [DEPTH];
    logic                  pal_reserved[DEPTH];
    logic [OUT_USES_W-1:0] pal_uses    [DEPTH];
    logic [LEN_W-1:0]      search_len;

    t_match pending_matches[$];
    int     fails = 0;

    task automatic set_default(input int n, input int r, input int g, input int b,
                               input int uses);
        pal_red[n]   = r[COLOR_W-1:0];
        pal_green[n] = g[COLOR_W-1:0];
        pal_blue[n]  = b[COLOR_W-1:0];
        pal_uses[n]  = uses[OUT_USES_W-1:0];
    endtask

    task automatic load_default_palette();
        int n;
        int level;
        for (n = 0; n < DEPTH; n++) begin
            set_default(n, 0, 0, 0, 0);
            pal_reserved[n] = 1'b0;
        end
        set_default(IDX_WHITE, FULL_LEVEL, FULL_LEVEL, FULL_LEVEL, USES_BASE);
        set_default(IDX_BLACK, 0, 0, 0, USES_BASE);
        n = IDX_CUBE_FIRST;
        for (int r = 0; r <= CUBE_DIGIT_MAX; r++)
            for (int g = 0; g <= CUBE_DIGIT_MAX; g++)
                for (int b = 0; b <= CUBE_DIGIT_MAX; b++) begin
                    set_default(n, r * CUBE_STEP, g * CUBE_STEP, b * CUBE_STEP, USES_CUBE);
                    n++;
                end
        for (int s = 0; s <= IDX_GRAY_LAST - IDX_GRAY_FIRST; s++) begin
            level = GRAY_STEP * (2 * s + 1);
            set_default(IDX_GRAY_FIRST + s, level, level, level, USES_BASE);
        end
        set_default(IDX_BLACK_END, 0, 0, 0, USES_BASE);
        search_len = LEN_RESET;
    endtask

    // scan in index order, keep the first strictly smaller distance
    task automatic find_nearest(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                                input logic [COLOR_W-1:0] b, output t_match m);
        int limit;
        int best;
        int best_d;
        int dr, dg, db, d;
        limit  = (search_len > DEPTH) ? DEPTH : int'(search_len);
        best   = 0;
        best_d = int'(NO_MATCH_DIST);
        for (int n = 0; n < limit; n++) begin
            if (!pal_reserved[n]) begin
                dr = int'(pal_red[n]) - int'(r);
                dg = int'(pal_green[n]) - int'(g);
                db = int'(pal_blue[n]) - int'(b);
                d  = dr * dr + dg * dg + db * db;
                if (d < best_d) begin
                    best_d = d;
                    best   = n;
                end
            end
        end
        if (pal_uses[best] != USES_MAX)
            pal_uses[best] = pal_uses[best] + 1'b1;
        m.index    = best[OUT_IDX_W-1:0];
        m.distance = best_d[DIST_W-1:0];
        m.uses     = pal_uses[best];
    endtask

    always @(posedge i_clk) begin : watch
        t_match want;
        t_match got;
        if (!i_rst_n) begin
            load_default_palette();
            pending_matches.delete();
        end else begin
            if (i_done) begin
                got = '{index: i_color_index, distance: i_least_distance,
                        uses: i_uses_after};
                if (pending_matches.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result index %0d dist %0d uses %0d",
                                 $realtime, got.index, got.distance, got.uses);
                end else begin
                    want = pending_matches.pop_front();
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: mismatch index exp %0d got %0d, dist exp %0d ",
                                      "got %0d, uses exp %0d got %0d"}, $realtime,
                                     want.index, got.index, want.distance, got.distance,
                                     want.uses, got.uses);
                    end
                end
            end
            if (i_cfg_wr_en)
                search_len = i_cfg_wr_data;
            if (i_start && !i_busy) begin
                if (i_action == ACT_MAP) begin
                    find_nearest(i_red_value, i_green_value, i_blue_value, want);
                    pending_matches.push_back(want);
                end else begin
                    pal_red[i_entry_index]      = i_red_value;
                    pal_green[i_entry_index]    = i_green_value;
                    pal_blue[i_entry_index]     = i_blue_value;
                    pal_reserved[i_entry_index] = i_reserved_mark;
                    pal_uses[i_entry_index]     = i_initial_uses;
                end
            end
        end
        o_pending    <= pending_matches.size();
        o_fail_count <= fails;
    end

endmodule

// ===== test/nearest_palette_color_unit_tb.sv =====
`timescale 1ns / 100ps

module nearest_palette_color_unit_tb;
    import npc_pkg::*;

    localparam int RUN_LIMIT       = 2000000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 108;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_start         = 1'b0;
    logic                  i_cfg_wr_en     = 1'b0;
    logic [LEN_W-1:0]      i_cfg_wr_data   = '0;
    logic                  i_action        = ACT_WRITE;
    logic [7:0]            i_entry_index   = '0;
    logic [COLOR_W-1:0]    i_red_value     = '0;
    logic [COLOR_W-1:0]    i_green_value   = '0;
    logic [COLOR_W-1:0]    i_blue_value    = '0;
    logic                  i_reserved_mark = 1'b0;
    logic [IN_USES_W-1:0]  i_initial_uses  = '0;
    logic                  o_busy;
    logic                  o_done;
    logic [OUT_IDX_W-1:0]  o_color_index;
    logic [DIST_W-1:0]     o_least_distance;
    logic [OUT_USES_W-1:0] o_uses_after;

    int fail_count;
    int match_backlog;
    int cycles = 0;
    int cur_len = int'(LEN_RESET);
    bit steady = 1'b0;
    logic [COLOR_W-1:0] last_red = '0, last_green = '0, last_blue = '0;

    int phase_len[PHASES] = '{256, 1, 511, 0, 3, 257, 0, 8, 0, 255, 2, 254};

    nearest_palette_color_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_red_value     (i_red_value),
        .i_green_value   (i_green_value),
        .i_blue_value    (i_blue_value),
        .i_reserved_mark (i_reserved_mark),
        .i_initial_uses  (i_initial_uses),
        .o_done          (o_done),
        .o_color_index   (o_color_index),
        .o_least_distance(o_least_distance),
        .o_uses_after    (o_uses_after)
    );

    palette_match_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_action        (i_action),
        .i_entry_index   (i_entry_index),
        .i_red_value     (i_red_value),
        .i_green_value   (i_green_value),
        .i_blue_value    (i_blue_value),
        .i_reserved_mark (i_reserved_mark),
        .i_initial_uses  (i_initial_uses),
        .i_done          (o_done),
        .i_color_index   (o_color_index),
        .i_least_distance(o_least_distance),
        .i_uses_after    (o_uses_after),
        .o_fail_count    (fail_count),
        .o_pending       (match_backlog)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_gap();
        int sel;
        sel = int'($urandom_range(0, 99));
        if (steady || sel < 50)
            return 0;
        else if (sel < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    // color level near one of the cube steps
    function automatic logic [COLOR_W-1:0] near_level();
        int v;
        v = CUBE_STEP * int'($urandom_range(0, CUBE_DIGIT_MAX))
            + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > FULL_LEVEL)
            v = FULL_LEVEL;
        return v[COLOR_W-1:0];
    endfunction

    task automatic send_item(input logic act, input logic [7:0] idx,
                             input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                             input logic [COLOR_W-1:0] b, input logic rsv,
                             input logic [IN_USES_W-1:0] uses);
        int gap;
        i_action        <= act;
        i_entry_index   <= idx;
        i_red_value     <= r;
        i_green_value   <= g;
        i_blue_value    <= b;
        i_reserved_mark <= rsv;
        i_initial_uses  <= uses;
        i_start         <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        if (act == ACT_WRITE) begin
            last_red   = r;
            last_green = g;
            last_blue  = b;
        end
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (match_backlog != 0 || o_busy)
            @(posedge i_clk);
    endtask

    task automatic set_length(input int len);
        i_start <= 1'b0;
        drain();
        // a write item gives no result, so let it settle too
        repeat (8) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len[LEN_W-1:0];
        cur_len = len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_item();
        int sel;
        int v;
        logic [7:0] idx;
        logic [COLOR_W-1:0] r, g, b;
        logic [IN_USES_W-1:0] uses;
        sel = int'($urandom_range(0, 99));
        if (sel < 45) begin
            case ($urandom_range(0, 3))
                0, 1: idx = 8'($urandom_range(0, 7));
                2: idx = 8'($urandom_range(0, 255));
                default: begin
                    v = cur_len - 1 + int'($urandom_range(0, 1));
                    if (v < 0)
                        v = 0;
                    if (v > 255)
                        v = 255;
                    idx = v[7:0];
                end
            endcase
            if ($urandom_range(0, 1)) begin
                r = near_level();
                g = near_level();
                b = near_level();
            end else begin
                r = COLOR_W'($urandom_range(0, 255));
                g = COLOR_W'($urandom_range(0, 255));
                b = COLOR_W'($urandom_range(0, 255));
            end
            case ($urandom_range(0, 9))
                0: uses = '1;
                1: uses = {{(IN_USES_W-1){1'b1}}, 1'b0};
                2: uses = '0;
                default: uses = IN_USES_W'($urandom_range(0, 24'hFFFFFF));
            endcase
            send_item(ACT_WRITE, idx, r, g, b, $urandom_range(0, 3) == 0, uses);
        end else begin
            case ($urandom_range(0, 3))
                0: begin
                    r = COLOR_W'($urandom_range(0, 255));
                    g = COLOR_W'($urandom_range(0, 255));
                    b = COLOR_W'($urandom_range(0, 255));
                end
                1: begin
                    r = near_level();
                    g = near_level();
                    b = near_level();
                end
                2: begin
                    r = last_red;
                    g = last_green;
                    b = last_blue;
                end
                default: begin
                    r = $urandom_range(0, 1) ? COLOR_W'(FULL_LEVEL) : '0;
                    g = $urandom_range(0, 1) ? COLOR_W'(FULL_LEVEL) : '0;
                    b = $urandom_range(0, 1) ? COLOR_W'(FULL_LEVEL) : '0;
                end
            endcase
            // unused fields carry noise on a map item
            send_item(ACT_MAP, 8'($urandom_range(0, 255)), r, g, b,
                      1'($urandom_range(0, 1)),
                      IN_USES_W'($urandom_range(0, 24'hFFFFFF)));
        end
    endtask

    initial begin
        int len;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default palette, duplicate blacks and the gray ramp
        send_item(ACT_MAP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 24'd0);
        send_item(ACT_MAP, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0, 24'd0);
        send_item(ACT_MAP, 8'd0, 8'd255, 8'd0, 8'd0, 1'b0, 24'd0);
        send_item(ACT_MAP, 8'd0, 8'd128, 8'd128, 8'd128, 1'b0, 24'd0);
        send_item(ACT_MAP, 8'd0, 8'd25, 8'd25, 8'd25, 1'b0, 24'd0);
        send_item(ACT_MAP, 8'd0, 8'd0, 8'd255, 8'd0, 1'b0, 24'd0);
        // use count saturation
        send_item(ACT_WRITE, 8'd5, 8'd1, 8'd2, 8'd3, 1'b0, 24'hFFFFFE);
        send_item(ACT_MAP, 8'd0, 8'd1, 8'd2, 8'd3, 1'b0, 24'd0);
        send_item(ACT_MAP, 8'd0, 8'd1, 8'd2, 8'd3, 1'b0, 24'd0);
        // reserved white falls back to the cube corner
        send_item(ACT_WRITE, 8'd0, 8'd255, 8'd255, 8'd255, 1'b1, 24'd0);
        send_item(ACT_MAP, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0, 24'd0);
        // entries past the search length stay out of reach
        send_item(ACT_WRITE, 8'd254, 8'd10, 8'd200, 8'd30, 1'b0, 24'd5);
        send_item(ACT_WRITE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 24'hFFFFFF);
        send_item(ACT_MAP, 8'd0, 8'd10, 8'd200, 8'd30, 1'b0, 24'd0);
        // map with every unused field high
        send_item(ACT_MAP, 8'hFF, 8'd200, 8'd100, 8'd50, 1'b1, 24'hFFFFFF);
        send_item(ACT_WRITE, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0, 24'd0);
        send_item(ACT_MAP, 8'd0, 8'd0, 8'd0, 8'd1, 1'b0, 24'd0);
        send_item(ACT_WRITE, 8'd253, 8'd0, 8'd0, 8'd0, 1'b1, 24'hFFFFFF);
        send_item(ACT_MAP, 8'd0, 8'd3, 8'd3, 8'd3, 1'b0, 24'd0);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 6)
                len = int'($urandom_range(2, 40));
            else if (p == 8)
                len = int'($urandom_range(1, 511));
            else
                len = phase_len[p];
            set_length(len);
            steady = ($urandom_range(0, 3) == 0);
            repeat (ITEMS_PER_PHASE) random_item();
        end

        i_start <= 1'b0;
        drain();
        repeat (16) @(posedge i_clk);
        if (fail_count == 0 && match_backlog == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
